// ===== rtl/lslf_pkg.sv =====
// Shared types, constants and saturation helpers for the least-squares line fit.
`timescale 1ns / 1ps
`default_nettype none
package lslf_pkg;

  localparam int unsigned MAX_PAIRS_DEFAULT = 4096;

  localparam int unsigned DW = 16;   // sample width
  localparam int unsigned MW = 64;   // multiplier operand width
  localparam int unsigned WW = 128;  // wide working width
  localparam int unsigned OW = 48;   // slope and intercept width
  localparam int unsigned EW = 40;   // mean error width
  localparam int unsigned FW = 2;    // status width
  localparam int unsigned RW = 72;   // residual width

  localparam logic [FW-1:0] ST_OK       = 2'd0;
  localparam logic [FW-1:0] ST_ZERO_VAR = 2'd1;
  localparam logic [FW-1:0] ST_DROPPED  = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PASS1,
    OP_MUL_NXX,
    OP_MUL_SXX,
    OP_MUL_NXY,
    OP_MUL_SXY,
    OP_CHECK,
    OP_DIV_SLOPE,
    OP_MUL_SLOPE,
    OP_DIV_ICPT,
    OP_PASS2,
    OP_DIV_MAE,
    OP_ZERO,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic var_ok;
  } stat_t;

  // Apply the sign to a rounded magnitude and clamp to the signed output range.
  function automatic logic signed [OW-1:0] sat_signed(input logic neg,
                                                      input logic [WW-1:0] mag);
    logic [WW-1:0] lim;
    lim = {{(WW-OW){1'b0}}, 1'b1, {(OW-1){1'b0}}};
    if (neg) begin
      if (mag > lim) return lim[OW-1:0];
      return OW'(0) - mag[OW-1:0];
    end
    if (mag >= lim) return {1'b0, {(OW-1){1'b1}}};
    return mag[OW-1:0];
  endfunction

  function automatic logic [EW-1:0] sat_unsigned(input logic [WW-1:0] mag);
    if (mag[WW-1:EW] != '0) return '1;
    return mag[EW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lslf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lslf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lslf_mul.sv =====
// Shift-and-add signed multiplier, one partial product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lslf_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [lslf_pkg::MW-1:0] a,
  input  logic signed [lslf_pkg::MW-1:0] b,
  output logic signed [lslf_pkg::WW-1:0] prod,
  output logic                          done
);
  import lslf_pkg::*;

  localparam int unsigned CNW = $clog2(MW);

  logic [WW-1:0]  acc;
  logic [WW-1:0]  mcand;
  logic [MW-1:0]  mplier;
  logic           neg;
  logic [CNW-1:0] cnt;
  logic           run;
  logic [MW-1:0]  ua;
  logic [MW-1:0]  ub;

  assign ua   = a[MW-1] ? MW'(-a) : MW'(a);
  assign ub   = b[MW-1] ? MW'(-b) : MW'(b);
  assign prod = neg ? -$signed(acc) : $signed(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run    <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= WW'(ua);
        mplier <= ub;
        neg    <= a[MW-1] ^ b[MW-1];
      end else if (run) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + CNW'(1);
        if (cnt == CNW'(MW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lslf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, rounded half up.
`timescale 1ns / 1ps
`default_nettype none
module lslf_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [lslf_pkg::WW-1:0] num,
  input  logic [lslf_pkg::WW-1:0] den,
  output logic [lslf_pkg::WW-1:0] quo,
  output logic                   done
);
  import lslf_pkg::*;

  localparam int unsigned CNW = $clog2(WW);

  logic [WW-1:0]  rem;
  logic [WW-1:0]  qq;
  logic [WW-1:0]  dd;
  logic [CNW-1:0] cnt;
  logic           run;
  logic [WW:0]    rs;
  logic           ge;

  assign rs  = {rem, qq[WW-1]};
  assign ge  = rs >= {1'b0, dd};
  // round half up on the final remainder
  assign quo = qq + WW'({rem, 1'b0} >= {1'b0, dd});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        qq  <= num;
        dd  <= den;
      end else if (run) begin
        rem <= ge ? WW'(rs - {1'b0, dd}) : rs[WW-1:0];
        qq  <= {qq[WW-2:0], ge};
        cnt <= cnt + CNW'(1);
        if (cnt == CNW'(WW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lslf_dp.sv =====
// Datapath: pair store, running totals, pass pipeline, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module lslf_dp #(
  parameter int unsigned MAX_PAIRS = lslf_pkg::MAX_PAIRS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic signed [lslf_pkg::DW-1:0] x_sample,
  input  logic signed [lslf_pkg::DW-1:0] y_sample,
  input  lslf_pkg::cmd_t                 cmd,
  output lslf_pkg::stat_t                stat,
  output logic signed [lslf_pkg::OW-1:0] slope,
  output logic signed [lslf_pkg::OW-1:0] intercept,
  output logic [lslf_pkg::EW-1:0]        mean_abs_error,
  output logic [lslf_pkg::FW-1:0]        fit_status
);
  import lslf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned AW = $clog2(MAX_PAIRS);
  localparam int unsigned SW = DW + CW;

  logic [CW-1:0]         count;
  logic signed [SW-1:0]  x_tot;
  logic signed [SW-1:0]  y_tot;
  logic                  dropped;
  logic                  full;

  logic [CW-1:0]         idx;
  logic                  issuing;
  logic                  v1;
  logic                  v2;
  logic [2*DW-1:0]       rdata;
  logic signed [DW-1:0]  px;
  logic signed [DW-1:0]  py;

  logic signed [2*DW-1:0] p_xx;
  logic signed [2*DW-1:0] p_xy;
  logic signed [MW-1:0]   p_sx;
  logic signed [RW-1:0]   base;
  logic signed [RW-1:0]   resid;
  logic [RW-1:0]          resid_abs;
  logic signed [MW-1:0]   sxx;
  logic signed [MW-1:0]   sxy;
  logic [WW-1:0]          sabs;

  logic signed [WW-1:0]  var_n;
  logic signed [WW-1:0]  cov_n;
  logic signed [WW-1:0]  aux;
  logic signed [OW-1:0]  slope_r;
  logic signed [OW-1:0]  icpt_r;
  logic [EW-1:0]         mae_r;
  logic                  zero_var;

  logic                  is_pass;
  logic                  is_mul;
  logic                  is_div;
  logic signed [MW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [WW-1:0]  prod;
  logic                  mul_done;
  logic [WW-1:0]         div_num;
  logic [WW-1:0]         div_den;
  logic                  div_neg_in;
  logic                  div_neg;
  logic [WW-1:0]         quo;
  logic                  div_done;
  logic signed [WW-1:0]  t_slope;
  logic signed [WW-1:0]  t_icpt;
  logic [WW-1:0]         den_n;

  assign full = (count == CW'(MAX_PAIRS));

  lslf_ram #(.WIDTH(2*DW), .DEPTH(MAX_PAIRS)) u_store (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (count[AW-1:0]),
    .wdata ({y_sample, x_sample}),
    .re    (issuing),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign px = rdata[DW-1:0];
  assign py = rdata[2*DW-1:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      x_tot   <= '0;
      y_tot   <= '0;
      dropped <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      count   <= '0;
      x_tot   <= '0;
      y_tot   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (!full) begin
        count <= count + CW'(1);
        x_tot <= x_tot + SW'(x_sample);
        y_tot <= y_tot + SW'(y_sample);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  assign is_pass = (cmd.op == OP_PASS1) || (cmd.op == OP_PASS2);
  assign is_mul  = (cmd.op == OP_MUL_NXX) || (cmd.op == OP_MUL_SXX) ||
                   (cmd.op == OP_MUL_NXY) || (cmd.op == OP_MUL_SXY) ||
                   (cmd.op == OP_MUL_SLOPE);
  assign is_div  = (cmd.op == OP_DIV_SLOPE) || (cmd.op == OP_DIV_ICPT) ||
                   (cmd.op == OP_DIV_MAE);

  // address issue and pipeline valids for both passes over the store
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      if (cmd.go && is_pass) begin
        idx     <= '0;
        issuing <= 1'b1;
      end else if (issuing) begin
        idx <= idx + CW'(1);
        if (idx == count - CW'(1)) issuing <= 1'b0;
      end
      v1 <= issuing;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      p_xx <= px * px;
      p_xy <= px * py;
      p_sx <= slope_r * px;
      base <= (RW'(icpt_r) <<< 8) - (RW'(py) <<< 24);
    end
  end

  assign resid     = RW'(p_sx) + base;
  assign resid_abs = resid[RW-1] ? RW'(-resid) : RW'(resid);

  always_ff @(posedge clk) begin
    if (cmd.go && cmd.op == OP_PASS1) begin
      sxx <= '0;
      sxy <= '0;
    end else if (v2 && cmd.op == OP_PASS1) begin
      sxx <= sxx + MW'(p_xx);
      sxy <= sxy + MW'(p_xy);
    end
    if (cmd.go && cmd.op == OP_PASS2) sabs <= '0;
    else if (v2 && cmd.op == OP_PASS2) sabs <= sabs + WW'(resid_abs);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_NXX: begin
        mul_a = $signed(MW'(count));
        mul_b = sxx;
      end
      OP_MUL_SXX: begin
        mul_a = MW'(x_tot);
        mul_b = MW'(x_tot);
      end
      OP_MUL_NXY: begin
        mul_a = $signed(MW'(count));
        mul_b = sxy;
      end
      OP_MUL_SXY: begin
        mul_a = MW'(x_tot);
        mul_b = MW'(y_tot);
      end
      OP_MUL_SLOPE: begin
        mul_a = MW'(slope_r);
        mul_b = MW'(x_tot);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lslf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.go && is_mul),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  assign t_slope = cov_n <<< 24;
  assign t_icpt  = (WW'(y_tot) <<< 24) - aux;
  assign den_n   = WW'({count, 8'b0});

  always_comb begin
    div_num    = '0;
    div_den    = den_n;
    div_neg_in = 1'b0;
    unique case (cmd.op)
      OP_DIV_SLOPE: begin
        div_neg_in = t_slope[WW-1];
        div_num    = t_slope[WW-1] ? WW'(-t_slope) : WW'(t_slope);
        div_den    = WW'(var_n);
      end
      OP_DIV_ICPT: begin
        div_neg_in = t_icpt[WW-1];
        div_num    = t_icpt[WW-1] ? WW'(-t_icpt) : WW'(t_icpt);
      end
      OP_DIV_MAE: begin
        div_num = sabs;
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  lslf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.go && is_div),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.go && is_div) div_neg <= div_neg_in;
    if (mul_done) begin
      unique case (cmd.op)
        OP_MUL_NXX:   var_n <= prod;
        OP_MUL_SXX:   var_n <= var_n - prod;
        OP_MUL_NXY:   cov_n <= prod;
        OP_MUL_SXY:   cov_n <= cov_n - prod;
        OP_MUL_SLOPE: aux   <= prod;
        default:      aux   <= aux;
      endcase
    end
    if (div_done) begin
      unique case (cmd.op)
        OP_DIV_SLOPE: slope_r <= sat_signed(div_neg, quo);
        OP_DIV_ICPT:  icpt_r  <= sat_signed(div_neg, quo);
        OP_DIV_MAE:   mae_r   <= sat_unsigned(quo);
        default:      mae_r   <= mae_r;
      endcase
    end
    if (cmd.go && cmd.op == OP_ZERO) begin
      slope_r <= '0;
      icpt_r  <= '0;
      mae_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_var <= 1'b0;
    end else if (cmd.go && cmd.op == OP_PASS1) begin
      zero_var <= 1'b0;
    end else if (cmd.go && cmd.op == OP_ZERO) begin
      zero_var <= 1'b1;
    end
  end

  always_comb begin
    stat.var_ok = (count != '0) && !var_n[WW-1] && (var_n != '0);
    if (is_pass)     stat.done = !issuing && !v1 && !v2;
    else if (is_mul) stat.done = mul_done;
    else if (is_div) stat.done = div_done;
    else             stat.done = 1'b0;
  end

  assign slope          = slope_r;
  assign intercept      = icpt_r;
  assign mean_abs_error = mae_r;
  assign fit_status     = zero_var ? ST_ZERO_VAR : (dropped ? ST_DROPPED : ST_OK);

endmodule
`default_nettype wire

// ===== rtl/lslf_ctrl.sv =====
// Controller: sequences the passes, products and quotients of one fit.
`timescale 1ns / 1ps
`default_nettype none
module lslf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            last_pair,
  input  lslf_pkg::stat_t stat,
  output lslf_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import lslf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS1,
    S_MUL_NXX,
    S_MUL_SXX,
    S_MUL_NXY,
    S_MUL_SXY,
    S_CHECK,
    S_DIV_SLOPE,
    S_MUL_SLOPE,
    S_DIV_ICPT,
    S_PASS2,
    S_DIV_MAE,
    S_ZERO,
    S_EMIT
  } state_t;

  state_t state;
  logic   adv;

  // ignore a stale done in the launch cycle
  assign adv  = !cmd.go && stat.done;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cmd.op <= OP_IDLE;
      cmd.go <= 1'b0;
      done   <= 1'b0;
    end else begin
      cmd.go <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        S_IDLE: if (start && last_pair) begin
          state  <= S_PASS1;
          cmd.op <= OP_PASS1;
          cmd.go <= 1'b1;
        end
        S_PASS1: if (adv) begin
          state  <= S_MUL_NXX;
          cmd.op <= OP_MUL_NXX;
          cmd.go <= 1'b1;
        end
        S_MUL_NXX: if (adv) begin
          state  <= S_MUL_SXX;
          cmd.op <= OP_MUL_SXX;
          cmd.go <= 1'b1;
        end
        S_MUL_SXX: if (adv) begin
          state  <= S_MUL_NXY;
          cmd.op <= OP_MUL_NXY;
          cmd.go <= 1'b1;
        end
        S_MUL_NXY: if (adv) begin
          state  <= S_MUL_SXY;
          cmd.op <= OP_MUL_SXY;
          cmd.go <= 1'b1;
        end
        S_MUL_SXY: if (adv) begin
          state  <= S_CHECK;
          cmd.op <= OP_CHECK;
        end
        S_CHECK: begin
          if (stat.var_ok) begin
            state  <= S_DIV_SLOPE;
            cmd.op <= OP_DIV_SLOPE;
          end else begin
            state  <= S_ZERO;
            cmd.op <= OP_ZERO;
          end
          cmd.go <= 1'b1;
        end
        S_DIV_SLOPE: if (adv) begin
          state  <= S_MUL_SLOPE;
          cmd.op <= OP_MUL_SLOPE;
          cmd.go <= 1'b1;
        end
        S_MUL_SLOPE: if (adv) begin
          state  <= S_DIV_ICPT;
          cmd.op <= OP_DIV_ICPT;
          cmd.go <= 1'b1;
        end
        S_DIV_ICPT: if (adv) begin
          state  <= S_PASS2;
          cmd.op <= OP_PASS2;
          cmd.go <= 1'b1;
        end
        S_PASS2: if (adv) begin
          state  <= S_DIV_MAE;
          cmd.op <= OP_DIV_MAE;
          cmd.go <= 1'b1;
        end
        S_DIV_MAE: if (adv) begin
          state  <= S_EMIT;
          cmd.op <= OP_EMIT;
          done   <= 1'b1;
        end
        S_ZERO: begin
          state  <= S_EMIT;
          cmd.op <= OP_EMIT;
          done   <= 1'b1;
        end
        S_EMIT: begin
          state  <= S_IDLE;
          cmd.op <= OP_IDLE;
        end
        default: begin
          state  <= S_IDLE;
          cmd.op <= OP_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/least_squares_line_fit.sv =====
// Top level of the least-squares straight-line fit.
//
// Pairs enter on x_sample, y_sample and last_pair; a word is taken at a rising
// edge with start high and busy low. While loading, busy stays low and one
// pair is taken every cycle; each is written to the pair store and summed.
// Pairs beyond MAX_PAIRS are dropped and flagged in fit_status.
// The word with last_pair set starts the fit and raises busy. The fit makes a
// pass over the store, four products, one quotient, a further product, a second
// quotient, a second pass and a final quotient; the products and quotients share
// one bit-serial multiplier and one bit-serial divider.
// The result (slope, intercept, mean_abs_error, fit_status) is shown for one
// cycle with done high; it cannot be held off. busy falls the cycle after.
// With zero variance of x the three values are zero and fit_status is 1.
// Reset (rst, synchronous) empties the set and returns the block to idle;
// the store needs no clearing since only entries of the current set are read.
`timescale 1ns / 1ps
`default_nettype none
module least_squares_line_fit #(
  parameter int unsigned MAX_PAIRS = lslf_pkg::MAX_PAIRS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [lslf_pkg::DW-1:0] x_sample,
  input  logic signed [lslf_pkg::DW-1:0] y_sample,
  input  logic                           last_pair,
  output logic                           done,
  output logic signed [lslf_pkg::OW-1:0] slope,
  output logic signed [lslf_pkg::OW-1:0] intercept,
  output logic [lslf_pkg::EW-1:0]        mean_abs_error,
  output logic [lslf_pkg::FW-1:0]        fit_status
);
  import lslf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  accept;

  assign accept = start && !busy;

  lslf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .last_pair (last_pair),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  lslf_dp #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .x_sample       (x_sample),
    .y_sample       (y_sample),
    .cmd            (cmd),
    .stat           (stat),
    .slope          (slope),
    .intercept      (intercept),
    .mean_abs_error (mean_abs_error),
    .fit_status     (fit_status)
  );

endmodule
`default_nettype wire

// ===== rtl/lslf_checker.sv =====
// Port-level checks for the line fit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lslf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           last_pair,
  input logic                           done,
  input logic signed [lslf_pkg::OW-1:0] slope,
  input logic signed [lslf_pkg::OW-1:0] intercept,
  input logic [lslf_pkg::EW-1:0]        mean_abs_error,
  input logic [lslf_pkg::FW-1:0]        fit_status
);
  import lslf_pkg::*;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a fit");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_pair) |=> busy)
    else $error("last word did not start a fit");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_pair) |=> (!busy && !done))
    else $error("loading word stalled the input or gave a result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (fit_status == ST_OK || fit_status == ST_ZERO_VAR ||
              fit_status == ST_DROPPED))
    else $error("undefined status code");

  a_zero_var: assert property (@(posedge clk) disable iff (rst)
    (done && fit_status == ST_ZERO_VAR) |->
      (slope == '0 && intercept == '0 && mean_abs_error == '0))
    else $error("zero-variance result not cleared");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);
`default_nettype wire

// ===== verif/least_squares_line_fit_test.sv =====
// Self-checking bench for the least-squares line fit: directed rows, overfill, random sets.
`timescale 1ns / 1ps
module least_squares_line_fit_test;
  import lslf_pkg::*;

  localparam int unsigned CAP = MAX_PAIRS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE = 2 * CAP + 1000;

  typedef logic signed [127:0] wide_t;
  typedef logic [127:0] uwide_t;

  typedef struct {
    logic [OW-1:0] slope;
    logic [OW-1:0] icpt;
    logic [EW-1:0] mae;
    logic [FW-1:0] status;
  } fit_t;

  typedef struct {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic                 last;
    logic                 typed;  // expected fit typed in below
    fit_t                 fit;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic signed [DW-1:0] x_sample = '0;
  logic signed [DW-1:0] y_sample = '0;
  logic                 last_pair = 1'b0;
  logic                 busy, done;
  logic signed [OW-1:0] slope, intercept;
  logic [EW-1:0]        mean_abs_error;
  logic [FW-1:0]        fit_status;

  least_squares_line_fit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_sample(x_sample), .y_sample(y_sample), .last_pair(last_pair),
    .done(done), .slope(slope), .intercept(intercept),
    .mean_abs_error(mean_abs_error), .fit_status(fit_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the pair store and running sums
  logic signed [DW-1:0] xs [CAP];
  logic signed [DW-1:0] ys [CAP];
  int unsigned          npairs = 0;
  longint               xsum = 0, ysum = 0;
  logic                 dropped = 1'b0;

  fit_t   fits_due [$];
  int     errors = 0;
  int     idle_mode = 0;
  longint cycles = 0;

  function automatic uwide_t div_round(uwide_t a, uwide_t b);
    uwide_t q, r;
    q = a / b;
    r = a % b;
    if ((r << 1) >= b) q = q + 1;
    return q;
  endfunction

  function automatic logic signed [OW-1:0] div_sat48(wide_t num, wide_t den);
    uwide_t mag;
    uwide_t lim;
    lim = uwide_t'(1) << (OW - 1);
    mag = div_round(num < 0 ? uwide_t'(-num) : uwide_t'(num), uwide_t'(den));
    if (num < 0) begin
      if (mag > lim) return lim[OW-1:0];
      return -mag[OW-1:0];
    end
    if (mag >= lim) return {1'b0, {(OW-1){1'b1}}};
    return mag[OW-1:0];
  endfunction

  // Fold one pair into the set; on the last pair push the fitted line.
  function automatic void take_pair(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                                    logic last);
    wide_t  n, sxx, sxy, varn, covn, den, sx, sy, b, a, r, px, py;
    uwide_t sum, q;
    fit_t   f;
    if (npairs < CAP) begin
      xs[npairs] = x;
      ys[npairs] = y;
      npairs++;
      xsum += x;
      ysum += y;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    n = npairs; sx = xsum; sy = ysum; sxx = 0; sxy = 0;
    for (int i = 0; i < npairs; i++) begin
      px = xs[i]; py = ys[i];
      sxx += px * px;
      sxy += px * py;
    end
    varn = n * sxx - sx * sx;
    covn = n * sxy - sx * sy;
    f = '{slope: '0, icpt: '0, mae: '0, status: ST_ZERO_VAR};
    if (n != 0 && varn > 0) begin
      den = n * 256;
      b = div_sat48(covn <<< 24, varn);
      a = div_sat48(sy * (wide_t'(1) <<< 24) - b * sx, den);
      sum = 0;
      for (int i = 0; i < npairs; i++) begin
        px = xs[i]; py = ys[i];
        r = a * 256 + b * px - py * (wide_t'(1) <<< 24);
        sum += (r < 0) ? uwide_t'(-r) : uwide_t'(r);
      end
      q = div_round(sum, uwide_t'(den));
      f.slope = b[OW-1:0];
      f.icpt = a[OW-1:0];
      f.mae = (q[127:EW] != 0) ? '1 : q[EW-1:0];
      f.status = dropped ? ST_DROPPED : ST_OK;
    end
    fits_due.push_back(f);
    npairs = 0; xsum = 0; ysum = 0; dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    fit_t e;
    if (!rst && done) begin
      if (fits_due.size() == 0) begin
        $display("%0t: unexpected result slope=%h", $time, slope);
        errors++;
      end else begin
        e = fits_due.pop_front();
        if (slope !== e.slope) begin
          $display("%0t: slope exp %h got %h", $time, e.slope, slope);
          errors++;
        end
        if (intercept !== e.icpt) begin
          $display("%0t: intercept exp %h got %h", $time, e.icpt, intercept);
          errors++;
        end
        if (mean_abs_error !== e.mae) begin
          $display("%0t: mean_abs_error exp %h got %h", $time, e.mae, mean_abs_error);
          errors++;
        end
        if (fit_status !== e.status) begin
          $display("%0t: fit_status exp %0d got %0d", $time, e.status, fit_status);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (idle_mode == 0) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Present one word, hold until taken, then drop start for a random gap, if pick_gap gives one.
  task automatic send_pair(logic signed [DW-1:0] x, logic signed [DW-1:0] y, logic last);
    int gap;
    start <= 1'b1;
    x_sample <= x;
    y_sample <= y;
    last_pair <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    take_pair(x, y, last);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (fits_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_sample(int kind);
    case (kind)
      0: return $urandom_range(15) - 8;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return $urandom();
    endcase
  endfunction

  row_t plan [$];

  initial begin
    int   len, kind;
    logic signed [DW-1:0] xc;

    // single pair, equal x, opposite extremes, then loose rows for the predictor
    plan.push_back('{16'sh7fff, 16'sh8000, 1, 1, '{'0, '0, '0, ST_ZERO_VAR}});
    plan.push_back('{16'sd5, 16'sd1, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sd5, 16'sd9, 1, 1, '{'0, '0, '0, ST_ZERO_VAR}});
    plan.push_back('{16'sh8000, 16'sh8000, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sh7fff, 16'sh7fff, 1, 1, '{48'sd16777216, '0, '0, ST_OK}});
    plan.push_back('{16'sh8000, 16'sh7fff, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sh7fff, 16'sh8000, 1, 1,
                     '{-48'sd16777216, -48'sd65536, '0, ST_OK}});
    plan.push_back('{16'sd0, 16'sd0, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sd1, 16'sd3, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sd2, -16'sd7, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{-16'sd5, 16'sd100, 1, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sd0, 16'sh7fff, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sd1, 16'sh8000, 1, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sh5555, 16'shaaaa, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'shaaaa, 16'sh5555, 0, 0, '{'0, '0, '0, ST_OK}});
    plan.push_back('{16'sh1234, 16'shfedc, 1, 0, '{'0, '0, '0, ST_OK}});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_pair(plan[i].x, plan[i].y, plan[i].last);
      // typed rows replace what the predictor just queued
      if (plan[i].typed && plan[i].last) begin
        void'(fits_due.pop_back());
        fits_due.push_back(plan[i].fit);
      end
    end
    drain();

    // overfill the store: the last four pairs, the last word among them, are dropped
    idle_mode = 0;
    for (int i = 0; i < CAP + 4; i++)
      send_pair(rand_sample(2), rand_sample(2), i == CAP + 3);
    drain();

    for (int s = 0; s < 150; s++) begin
      idle_mode = $urandom_range(3) != 0;
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      kind = $urandom_range(5);
      xc = rand_sample(2);
      for (int i = 0; i < len; i++) begin
        // constant x sets exercise the zero-variance path
        send_pair(kind == 5 ? xc : rand_sample(kind % 3), rand_sample($urandom_range(2)),
                  i == len - 1);
      end
      if (s == 75) drain();
    end

    drain();
    repeat (SETTLE) begin
      @(posedge clk);
      if (fits_due.size() != 0) break;
    end
    if (errors == 0 && fits_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lslf_pkg.sv
rtl/lslf_ram.sv
rtl/lslf_mul.sv
rtl/lslf_div.sv
rtl/lslf_dp.sv
rtl/lslf_ctrl.sv
rtl/least_squares_line_fit.sv
rtl/lslf_checker.sv
verif/least_squares_line_fit_test.sv
